// ===== rtl/pcg32_shuffle_engine_assert.svh =====
// assertion macros for the pcg32 shuffle engine
`ifndef PCG32_SHUFFLE_ENGINE_ASSERT_SVH
`define PCG32_SHUFFLE_ENGINE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PSE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PSE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pcg_shuf_pkg.sv =====
// types, constants and helper functions of the pcg32 shuffle engine
`default_nettype none

package pcg_shuf_pkg;

	localparam int MAX_ENTRIES = 128;

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int WW = (CW > 8) ? CW : 8;
	localparam int DW = WW;

	localparam logic [WW-1:0] MAX_W = WW'(MAX_ENTRIES);
	localparam logic [7:0] DRAW_LIMIT = 8'd128;

	localparam logic [63:0] LCG_MUL = 64'h5851_F42D_4C95_7F2D;
	localparam logic [63:0] LCG_INC = 64'h1405_7B7E_F767_814F;

	localparam logic REG_SEED  = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	typedef enum logic [1:0] {
		FN_RESEED  = 2'd0,
		FN_SHUFFLE = 2'd1,
		FN_READ    = 2'd2,
		FN_DRAW    = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL,
		ST_MUL,
		ST_DIV,
		ST_RD_TOP,
		ST_RD_PICK,
		ST_WR_TOP,
		ST_WR_PICK,
		ST_READ,
		ST_LATCH,
		ST_DONE
	} state_t;

	// xsh-rr output of the old generator state
	function automatic logic [31:0] pcg_out(input logic [63:0] s);
		logic [63:0] x;
		logic [31:0] m;
		logic [4:0] r;
		logic [4:0] l;
		x = (s >> 18) ^ s;
		m = x[58:27];
		r = s[63:59];
		l = 5'd0 - r;
		return (m >> r) | (m << l);
	endfunction

	// table entry value for a counter
	function automatic logic [6:0] fit_val(input logic [CW-1:0] c);
		logic [WW-1:0] w;
		w = WW'(c);
		return w[6:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/pcg32_shuffle_engine.sv =====
// PCG32 XSH-RR generator with a Fisher-Yates shuffled order table. One word is
// taken at a time and each gives one result word. A generator step is a
// low-half 64-bit multiply on one shared 32x32 multiplier, and each modulo is a
// restoring remainder loop; a swap reads the top and the picked entry and then
// writes them back crosswise on the table memory, which has one read and one
// write port. A new word is taken as soon as the sequencer is idle, while the
// previous result may still wait in the output register.
`default_nettype none
`include "pcg32_shuffle_engine_assert.svh"

module pcg32_shuffle_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  func,
	input  wire logic [6:0]  entry_index,
	input  wire logic [7:0]  bound,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [6:0]       value,
	output logic             error
);
	import pcg_shuf_pkg::*;

	state_t state_q, state_d;

	logic [31:0]   seed_q;
	logic [7:0]    count_q;
	logic [63:0]   gen_q;
	logic [1:0]    phase_q;
	logic [4:0]    bit_q;
	logic [CW-1:0] i_q;
	logic          out_valid_q;

	func_t         func_q;
	logic [AW-1:0] idx_q;
	logic [7:0]    bsat_q;
	logic [31:0]   rng_q;
	logic [63:0]   prod_q;
	logic [63:0]   acc_q;
	logic [DW-1:0] rem_q;
	logic [6:0]    res_val_q;
	logic          res_err_q;
	logic [6:0]    held_q;
	logic [6:0]    value_q;
	logic          error_q;

	logic [6:0]    mem [MAX_ENTRIES];
	logic [6:0]    rdata_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [6:0]    mem_wdata;
	logic [AW-1:0] mem_raddr;

	logic          accept;
	logic          out_load;
	func_t         func_in;
	logic [WW-1:0] cnt_w;
	logic [WW-1:0] n_w;
	logic [CW-1:0] n_cnt;
	logic [WW-1:0] idx_w;
	logic          idx_ok;
	logic [CW-1:0] i_dec;
	logic [AW-1:0] top_addr;
	logic [AW-1:0] pick_addr;
	logic [DW-1:0] divisor;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic [DW-1:0] rem_nxt;
	logic [31:0]   mul_a;
	logic [31:0]   mul_b;
	logic [63:0]   mul_p;

	assign func_in   = func_t'(func);
	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign error     = error_q;

	// live count, capped at the table depth
	assign cnt_w  = WW'(count_q);
	assign n_w    = (cnt_w > MAX_W) ? MAX_W : cnt_w;
	assign n_cnt  = n_w[CW-1:0];
	assign idx_w  = WW'(entry_index);
	assign idx_ok = (idx_w < n_w);

	assign i_dec     = i_q - CW'(1);
	assign top_addr  = i_dec[AW-1:0];
	assign pick_addr = rem_q[AW-1:0];

	// shared remainder step
	assign divisor = (func_q == FN_DRAW) ? DW'(bsat_q) : DW'(i_q);
	assign trial   = {rem_q, rng_q[31]};
	assign diff    = trial - {1'b0, divisor};
	assign rem_nxt = (trial >= {1'b0, divisor}) ? diff[DW-1:0] : trial[DW-1:0];

	// shared multiplier, one partial product a cycle
	always_comb begin
		unique case (phase_q)
			2'd1: begin
				mul_a = gen_q[31:0];
				mul_b = LCG_MUL[63:32];
			end
			2'd2: begin
				mul_a = gen_q[63:32];
				mul_b = LCG_MUL[31:0];
			end
			default: begin
				mul_a = gen_q[31:0];
				mul_b = LCG_MUL[31:0];
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// sequencer
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = top_addr;
		mem_wdata = rdata_q;
		mem_raddr = top_addr;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (func_in)
						FN_RESEED:  state_d = ST_DONE;
						FN_SHUFFLE: state_d = (n_cnt == '0) ? ST_DONE : ST_FILL;
						FN_READ:    state_d = idx_ok ? ST_READ : ST_DONE;
						FN_DRAW:    state_d = (bound == 8'd0) ? ST_DONE : ST_MUL;
					endcase
				end
			end
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = i_q[AW-1:0];
				mem_wdata = fit_val(i_q);
				if (i_q == n_cnt - CW'(1)) begin
					state_d = (n_cnt > CW'(1)) ? ST_MUL : ST_DONE;
				end
			end
			ST_MUL: begin
				if (phase_q == 2'd3) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (bit_q == 5'd31) begin
					state_d = (func_q == FN_DRAW) ? ST_DONE : ST_RD_TOP;
				end
			end
			ST_RD_TOP: begin
				mem_raddr = top_addr;
				state_d   = ST_RD_PICK;
			end
			ST_RD_PICK: begin
				mem_raddr = pick_addr;
				state_d   = ST_WR_TOP;
			end
			ST_WR_TOP: begin
				mem_we    = 1'b1;
				mem_waddr = top_addr;
				mem_wdata = rdata_q;
				state_d   = ST_WR_PICK;
			end
			ST_WR_PICK: begin
				mem_we    = 1'b1;
				mem_waddr = pick_addr;
				mem_wdata = held_q;
				state_d   = (i_dec > CW'(1)) ? ST_MUL : ST_DONE;
			end
			ST_READ: begin
				mem_raddr = idx_q;
				state_d   = ST_LATCH;
			end
			ST_LATCH: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control and generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= '0;
			count_q     <= 8'd128;
			gen_q       <= 64'd1;
			phase_q     <= '0;
			bit_q       <= '0;
			i_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SEED:  seed_q  <= cfg_data;
					REG_COUNT: count_q <= cfg_data[7:0];
				endcase
			end
			phase_q <= (state_q == ST_MUL) ? phase_q + 2'd1 : 2'd0;
			bit_q   <= (state_q == ST_DIV) ? bit_q + 5'd1 : 5'd0;
			if (accept && func_in == FN_RESEED) begin
				gen_q <= {31'd0, seed_q, 1'b1};
			end
			if (accept) begin
				i_q <= '0;
			end
			if (state_q == ST_FILL) begin
				i_q <= (i_q == n_cnt - CW'(1)) ? n_cnt : i_q + CW'(1);
			end
			if (state_q == ST_MUL && phase_q == 2'd3) begin
				gen_q <= {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};
			end
			if (state_q == ST_WR_PICK) begin
				i_q <= i_dec;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q    <= func_in;
			idx_q     <= idx_w[AW-1:0];
			bsat_q    <= (bound > DRAW_LIMIT) ? DRAW_LIMIT : bound;
			res_val_q <= '0;
			res_err_q <= ((func_in == FN_READ) && !idx_ok) ||
			             ((func_in == FN_DRAW) && (bound == 8'd0));
		end
		if (state_q == ST_MUL) begin
			prod_q <= mul_p;
			rem_q  <= '0;
			unique case (phase_q)
				2'd0: rng_q <= pcg_out(gen_q);
				2'd1: acc_q <= prod_q + LCG_INC;
				2'd2: acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
				default: ;
			endcase
		end
		if (state_q == ST_DIV) begin
			rem_q <= rem_nxt;
			rng_q <= {rng_q[30:0], 1'b0};
			if (bit_q == 5'd31 && func_q == FN_DRAW) begin
				res_val_q <= rem_nxt[6:0];
			end
		end
		if (state_q == ST_RD_PICK) begin
			held_q <= rdata_q;
		end
		if (state_q == ST_LATCH) begin
			res_val_q <= rdata_q;
		end
		if (out_load) begin
			value_q <= res_val_q;
			error_q <= res_err_q;
		end
	end

	// order table
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	`PSE_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready, "ready after accepted word")
	`PSE_ASSERT_NOW(a_error_zero_value, out_valid && error, value == 7'd0, "error word with value")
	`PSE_ASSERT_NOW(a_rem_below_div, state_q == ST_DIV, rem_q < divisor, "remainder out of range")
	`PSE_ASSERT_NOW(a_pick_below_top, state_q == ST_RD_TOP, DW'(i_q) > rem_q, "swap pick past top")

endmodule

`default_nettype wire
